// File: rtl/pgrm_pkg.sv
// ----------------------------------------------------------------------------
// pgrm_pkg
// Shared constants and controller/datapath interface types for the gain and
// rms meter block.
// ----------------------------------------------------------------------------
`default_nettype none

package pgrm_pkg;

    localparam int MAX_CHUNK_SAMPLES = 1024;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 16;
    localparam int PROD_W   = SAMPLE_W + GAIN_W + 1;
    localparam int SQ_W     = 32;
    localparam int COUNT_W  = $clog2(MAX_CHUNK_SAMPLES + 1);
    // squares are at most 2^30 and fewer than 2^COUNT_W of them are summed
    localparam int SUM_W    = 30 + COUNT_W;
    localparam int ITER_W   = $clog2(SUM_W);
    localparam int SQRT_STEPS = SQ_W / 2;

    localparam int SAMPLE_MAX = 32767;
    localparam int SAMPLE_MIN = -32768;
    localparam int GAIN_RESET = 384;
    localparam int Q_SHIFT    = 8;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_Q8 = REG_IDX_W'(0);

    typedef struct packed {
        logic load;
        logic mul;
        logic scale;
        logic square;
        logic acc;
        logic div_step;
        logic sqrt_init;
        logic sqrt_step;
        logic hold;
        logic out_load;
    } pgrm_cmd_t;

    typedef struct packed {
        logic close_now;
    } pgrm_status_t;

endpackage

`default_nettype wire

// File: rtl/pgrm_datapath.sv
// ----------------------------------------------------------------------------
// pgrm_datapath
// Gain multiply, scaling and saturation, square accumulation, serial divide
// and serial square root, output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module pgrm_datapath
    import pgrm_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire pgrm_cmd_t                   cmd,
    output pgrm_status_t                     status,
    input  wire logic [GAIN_W-1:0]           gain,
    input  wire logic signed [SAMPLE_W-1:0]  sample_in,
    input  wire logic                        chunk_last,
    output logic signed [SAMPLE_W-1:0]       sample_out,
    output logic [SAMPLE_W-1:0]              rms_level,
    output logic                             rms_new
);

    localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(SAMPLE_MAX);
    localparam logic signed [PROD_W-1:0] SAT_LO = PROD_W'(SAMPLE_MIN);
    localparam logic signed [PROD_W-1:0] ROUND_ADJ = PROD_W'((1 << Q_SHIFT) - 1);

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       last_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [SAMPLE_W-1:0] val_reg;
    logic [SQ_W-1:0]            sq_reg;
    logic [SUM_W-1:0]           sum_reg;
    logic [COUNT_W-1:0]         cnt_reg;
    logic                       close_reg;
    logic [SUM_W-1:0]           quo_reg;
    logic [COUNT_W-1:0]         rem_reg;
    logic [COUNT_W-1:0]         dvsr_reg;
    logic [SQ_W-1:0]            sq_rem_reg;
    logic [SQ_W-1:0]            root_reg;
    logic [SQ_W-1:0]            bit_reg;
    logic [SAMPLE_W-1:0]        held_reg;
    logic signed [SAMPLE_W-1:0] sample_out_reg;
    logic [SAMPLE_W-1:0]        rms_level_reg;
    logic                       rms_new_reg;

    logic signed [GAIN_W:0]     gain_s;
    logic signed [PROD_W-1:0]   prod_full;
    logic signed [PROD_W-1:0]   prod_adj;
    logic signed [PROD_W-1:0]   scaled;
    logic signed [SAMPLE_W-1:0] val_next;
    logic signed [SQ_W-1:0]     sq_full;
    logic [SUM_W-1:0]           sum_new;
    logic [COUNT_W-1:0]         cnt_new;
    logic [COUNT_W:0]           div_shifted;
    logic [COUNT_W:0]           div_diff;
    logic [SQ_W-1:0]            sqrt_trial;
    logic                       sqrt_ge;

    assign gain_s    = {1'b0, gain};
    assign prod_full = sample_reg * gain_s;

    // truncate toward zero: bias negative products before the arithmetic shift
    assign prod_adj = prod_reg + (prod_reg[PROD_W-1] ? ROUND_ADJ : '0);
    assign scaled   = prod_adj >>> Q_SHIFT;

    always_comb
    begin
        if (scaled > SAT_HI)
        begin
            val_next = SAMPLE_W'(SAMPLE_MAX);
        end
        else if (scaled < SAT_LO)
        begin
            val_next = SAMPLE_W'(SAMPLE_MIN);
        end
        else
        begin
            val_next = scaled[SAMPLE_W-1:0];
        end
    end

    assign sq_full = val_reg * val_reg;
    assign sum_new = sum_reg + SUM_W'(sq_reg);
    assign cnt_new = cnt_reg + COUNT_W'(1);

    assign status.close_now = last_reg || (cnt_new == COUNT_W'(MAX_CHUNK_SAMPLES));

    // restoring divide, one quotient bit per step
    assign div_shifted = {rem_reg, quo_reg[SUM_W-1]};
    assign div_diff    = div_shifted - {1'b0, dvsr_reg};

    // bit-by-bit square root
    assign sqrt_trial = root_reg + bit_reg;
    assign sqrt_ge    = sq_rem_reg >= sqrt_trial;

    // chunk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            cnt_reg  <= '0;
            held_reg <= '0;
        end
        else
        begin
            if (cmd.acc)
            begin
                if (status.close_now)
                begin
                    sum_reg <= '0;
                    cnt_reg <= '0;
                end
                else
                begin
                    sum_reg <= sum_new;
                    cnt_reg <= cnt_new;
                end
            end
            if (cmd.hold)
            begin
                held_reg <= root_reg[SAMPLE_W-1:0];
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_reg <= sample_in;
            last_reg   <= chunk_last;
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_full;
        end
        if (cmd.scale)
        begin
            val_reg <= val_next;
        end
        if (cmd.square)
        begin
            sq_reg <= sq_full;
        end
        if (cmd.acc)
        begin
            close_reg <= status.close_now;
            quo_reg   <= sum_new;
            rem_reg   <= '0;
            dvsr_reg  <= cnt_new;
        end
        if (cmd.div_step)
        begin
            if (!div_diff[COUNT_W])
            begin
                rem_reg <= div_diff[COUNT_W-1:0];
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= div_shifted[COUNT_W-1:0];
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
            end
        end
        if (cmd.sqrt_init)
        begin
            sq_rem_reg <= quo_reg[SQ_W-1:0];
            root_reg   <= '0;
            bit_reg    <= SQ_W'(1) << (SQ_W - 2);
        end
        if (cmd.sqrt_step)
        begin
            if (sqrt_ge)
            begin
                sq_rem_reg <= sq_rem_reg - sqrt_trial;
                root_reg   <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.out_load)
        begin
            sample_out_reg <= val_reg;
            rms_level_reg  <= held_reg;
            rms_new_reg    <= close_reg;
        end
    end

    assign sample_out = sample_out_reg;
    assign rms_level  = rms_level_reg;
    assign rms_new    = rms_new_reg;

endmodule

`default_nettype wire

// File: rtl/pgrm_ctrl.sv
// ----------------------------------------------------------------------------
// pgrm_ctrl
// Sequencer for one sample: multiply, scale, square, accumulate, and on a
// chunk close the serial divide and square root; owns the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module pgrm_ctrl
    import pgrm_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  wire logic         out_ready,
    input  wire pgrm_status_t status,
    output pgrm_cmd_t         cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_SCALE,
        S_SQUARE,
        S_ACC,
        S_DIV,
        S_SQRT_INIT,
        S_SQRT,
        S_HOLD,
        S_OUT
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [ITER_W-1:0] iter_reg;
    logic [ITER_W-1:0] iter_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_free;
    logic              in_fire;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        iter_next      = iter_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = S_SQUARE;
            end
            S_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc = 1'b1;
                if (status.close_now)
                begin
                    iter_next  = ITER_W'(SUM_W - 1);
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                iter_next    = iter_reg - ITER_W'(1);
                if (iter_reg == '0)
                begin
                    state_next = S_SQRT_INIT;
                end
            end
            S_SQRT_INIT:
            begin
                cmd.sqrt_init = 1'b1;
                iter_next     = ITER_W'(SQRT_STEPS - 1);
                state_next    = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                iter_next     = iter_reg - ITER_W'(1);
                if (iter_reg == '0)
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                cmd.hold   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_MUL))
        else $error("accepted word did not start the multiply");

    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (iter_reg <= ITER_W'(SUM_W - 1)))
        else $error("divide step counter out of range");

    a_sqrt_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SQRT) && (iter_reg == '0) |=> (state_reg == S_HOLD))
        else $error("square root did not finish after its last step");

    a_out_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("result loaded without raising out_valid");

endmodule

`default_nettype wire

// File: rtl/pcm_gain_rms_meter_unit.sv
// ----------------------------------------------------------------------------
// pcm_gain_rms_meter_unit
// Q8 digital gain with saturation and a per-chunk integer rms meter.
// ----------------------------------------------------------------------------
// input channel (in_valid/in_ready): one word is a signed 16-bit sample plus
//   chunk_last marking the final sample of a measurement chunk
// output channel (out_valid/out_ready): one word per input word with the
//   gained sample, the held rms level and rms_new on a chunk close
// apb port: gain_q8 at byte address 0 (q8, 256 is unity, reset 384)
// sequence: an ordinary sample passes the multiply, scale, square and
//   accumulate states before raising out_valid; a closing sample (chunk_last,
//   or the chunk reaching 1024 samples) adds a 41-step restoring divide and a
//   16-step square root; one word is in flight, and in_ready is high only
//   while the sequencer is idle
// stalls: the result sits in an output register, so the next word is still
//   accepted while the receiver stalls and then waits before its own output
// reset: clears the square sum, count and held level, gain returns to 384
// ----------------------------------------------------------------------------
`default_nettype none

module pcm_gain_rms_meter_unit
    import pgrm_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // sample input
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic signed [SAMPLE_W-1:0] sample_in,
    input  wire logic                       chunk_last,
    // result output
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic signed [SAMPLE_W-1:0]      sample_out,
    output logic [SAMPLE_W-1:0]             rms_level,
    output logic                            rms_new,
    // configuration
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [PADDR_W-1:0]         paddr,
    input  wire logic [PDATA_W-1:0]         pwdata,
    output logic [PDATA_W-1:0]              prdata,
    output logic                            pready
);

    pgrm_cmd_t           cmd;
    pgrm_status_t        status;
    logic [GAIN_W-1:0]   gain_q8_reg;
    logic [GAIN_W-1:0]   gain_q8_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                cfg_write;

    // register file: word-aligned, low address bits ignored
    assign reg_idx   = paddr[PADDR_W-1:2];
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        gain_q8_next = gain_q8_reg;
        if (cfg_write && (reg_idx == REG_GAIN_Q8))
        begin
            gain_q8_next = pwdata[GAIN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_q8_reg <= GAIN_W'(GAIN_RESET);
        end
        else
        begin
            gain_q8_reg <= gain_q8_next;
        end
    end

    // unknown addresses read as zero
    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_GAIN_Q8)
        begin
            prdata = PDATA_W'(gain_q8_reg);
        end
    end

    // sequencer: walks each word through the datapath steps
    pgrm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // arithmetic and chunk state
    pgrm_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .gain       (gain_q8_reg),
        .sample_in  (sample_in),
        .chunk_last (chunk_last),
        .sample_out (sample_out),
        .rms_level  (rms_level),
        .rms_new    (rms_new)
    );

endmodule

`default_nettype wire

// File: bench/pcm_gain_rms_meter_unit_tb.sv
// ----------------------------------------------------------------------------
// pcm_gain_rms_meter_unit_tb
// Self-checking bench for the q8 gain stage and chunk rms meter. Samples go in
// over the valid/ready input channel while the gain is set over the apb port.
// Every output word is compared field by field against a software copy of
// the gain, saturation, square sum and integer square root, with random
// idling on both channels, several gain settings and full-count chunk closes.
// ----------------------------------------------------------------------------

module pcm_gain_rms_meter_unit_tb;

    import pgrm_pkg::*;

    // unused register index, writes there must leave the gain alone
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = REG_IDX_W'(1);
    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 120;

    // one output word as the block should present it
    typedef struct {
        logic signed [SAMPLE_W-1:0] gained;
        logic [SAMPLE_W-1:0]        level;
        logic                       fresh;
    } meter_word_t;

    // ------------------------------------------------------------------------
    // software copy of the gain stage and the rms meter
    // ------------------------------------------------------------------------
    class rms_meter_tracker;
        bit [GAIN_W-1:0]       gain;
        longint unsigned       square_total;
        int                    chunk_fill;
        bit [SAMPLE_W-1:0]     level_held;
        meter_word_t           due_words[$];
        int                    mismatches;
        int                    words_seen;
        int                    chunks_closed;
        int                    full_closes;

        function new();
            gain = GAIN_W'(GAIN_RESET);
            square_total = 0;
            chunk_fill = 0;
            level_held = '0;
            mismatches = 0;
            words_seen = 0;
            chunks_closed = 0;
            full_closes = 0;
        endfunction

        function void set_gain(bit [GAIN_W-1:0] g);
            gain = g;
        endfunction

        function int pending();
            return due_words.size();
        endfunction

        function void note_mismatch(string what, longint want, longint got);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %0d, got %0d", what, want, got);
        endfunction

        // floor square root, one result bit at a time from the top
        function bit [SAMPLE_W-1:0] floor_root(longint unsigned n);
            bit [SAMPLE_W:0]  root;
            bit [SAMPLE_W:0]  trial;
            longint unsigned  trial_sq;
            root = '0;
            for (int b = SAMPLE_W; b >= 0; b--)
            begin
                trial = root | ((SAMPLE_W + 1)'(1) << b);
                trial_sq = longint'(trial) * longint'(trial);
                if (trial_sq <= n)
                    root = trial;
            end
            return root[SAMPLE_W-1:0];
        endfunction

        // accepted input sample: work out the word it will produce
        function void take_sample(logic signed [SAMPLE_W-1:0] s, logic last);
            longint      scaled;
            bit          closed;
            meter_word_t w;
            scaled = (longint'(s) * longint'(gain)) / 256;
            if (scaled > SAMPLE_MAX)
                scaled = SAMPLE_MAX;
            else if (scaled < SAMPLE_MIN)
                scaled = SAMPLE_MIN;
            square_total += longint'(scaled * scaled);
            chunk_fill++;
            closed = last || (chunk_fill >= MAX_CHUNK_SAMPLES);
            if (closed)
            begin
                if (!last)
                    full_closes++;
                chunks_closed++;
                level_held = floor_root(square_total / longint'(chunk_fill));
                square_total = 0;
                chunk_fill = 0;
            end
            w.gained = scaled[SAMPLE_W-1:0];
            w.level = level_held;
            w.fresh = closed;
            due_words.push_back(w);
        endfunction

        // accepted output word: compare with the oldest one due
        function void check_word(logic signed [SAMPLE_W-1:0] gained,
                                 logic [SAMPLE_W-1:0] level, logic fresh);
            meter_word_t w;
            words_seen++;
            if (due_words.size() == 0)
            begin
                note_mismatch("word with nothing due (sample_out)", 0, gained);
                return;
            end
            w = due_words.pop_front();
            if (gained !== w.gained)
                note_mismatch("sample_out", w.gained, gained);
            if (level !== w.level)
                note_mismatch("rms_level", w.level, level);
            if (fresh !== w.fresh)
                note_mismatch("rms_new", w.fresh, fresh);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // block hookup
    // ------------------------------------------------------------------------
    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] sample_in = '0;
    logic                       chunk_last = 1'b0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic [SAMPLE_W-1:0]        rms_level;
    logic                       rms_new;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [PADDR_W-1:0]         paddr = '0;
    logic [PDATA_W-1:0]         pwdata = '0;
    logic [PDATA_W-1:0]         prdata;
    logic                       pready;

    rms_meter_tracker tracker = new();

    bit idling_on = 1'b1;       // random gaps and stalls allowed
    int stall_left = 0;         // receiver stall cycles still to go
    int quiet_cycles = 0;       // cycles since the last accepted word
    int samples_sent = 0;
    int gain_settings = 0;

    pcm_gain_rms_meter_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample_in  (sample_in),
        .chunk_last (chunk_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .rms_level  (rms_level),
        .rms_new    (rms_new),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #6 clk = ~clk;

    // both handshakes are sampled at the edge, before any update lands
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                tracker.take_sample(sample_in, chunk_last);
            if (out_valid && out_ready)
                tracker.check_word(sample_out, rms_level, rms_new);
        end
    end

    // receiver side: ready most of the time, stalls come in bursts of random length
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (idling_on && $urandom_range(0, 9) == 0)
        begin
            stall_left <= $urandom_range(0, 16);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // watchdog: a long stretch with no word moving on either side is a hang
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
            $display("status: fail");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // drivers, all entered and left just after a rising edge
    // ------------------------------------------------------------------------

    // put one sample word up and hold it until the block takes it
    task automatic send_sample(logic signed [SAMPLE_W-1:0] s, logic last);
        in_valid <= 1'b1;
        sample_in <= s;
        chunk_last <= last;
        do
            @(posedge clk);
        while (!in_ready);
        samples_sent++;
    endtask

    task automatic sender_pause(int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // stop sending and wait until every word due has come out; the first
    // edge lets the monitor note a word taken at the edge just passed
    task automatic drain;
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending() != 0);
    endtask

    // apb write: setup cycle, then access cycle until pready
    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_GAIN_Q8)
        begin
            tracker.set_gain(val[GAIN_W-1:0]);
            gain_settings++;
        end
    endtask

    // apb read, data taken mid-way through the access cycle
    task automatic read_check(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] want);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        while (!pready)
            @(negedge clk);
        if (prdata !== want)
            tracker.note_mismatch("prdata", want, prdata);
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_gain(logic [GAIN_W-1:0] g);
        write_reg(REG_GAIN_Q8, PDATA_W'(g));
        read_check(REG_GAIN_Q8, PDATA_W'(g));
    endtask

    // mix of full-scale, near-zero and fully random samples
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return SAMPLE_W'(SAMPLE_MAX);
            1: return SAMPLE_W'(SAMPLE_MIN);
            2, 3: return SAMPLE_W'($urandom_range(0, 511)) - SAMPLE_W'(256);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // a run of random samples; chunk marks at roughly one in last_odds,
    // none at all when last_odds is zero (chunks then close on the full
    // count), and the run always ends on a marked sample; the first
    // pinned_min samples are all negative full scale
    task automatic run_samples(int n_items, int last_odds, int pinned_min);
        logic signed [SAMPLE_W-1:0] s;
        logic                       last;
        for (int i = 0; i < n_items; i++)
        begin
            s = (i < pinned_min) ? SAMPLE_W'(SAMPLE_MIN) : pick_sample();
            last = (i == n_items - 1) ||
                   (last_odds != 0 && $urandom_range(1, last_odds) == 1);
            send_sample(s, last);
            if (idling_on && $urandom_range(0, 7) == 0)
                sender_pause($urandom_range(1, 17));
        end
        drain();
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [GAIN_W-1:0] phase_gains[7];
        phase_gains = '{16'd1, 16'd255, 16'd257, 16'hFFFF, 16'd0,
                        GAIN_W'($urandom), GAIN_W'($urandom)};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // gain comes up at its reset value of 1.5
        read_check(REG_GAIN_Q8, PDATA_W'(GAIN_RESET));

        // reset gain: both ends saturate, odd negatives truncate toward zero
        send_sample(SAMPLE_W'(SAMPLE_MAX), 1'b0);
        send_sample(SAMPLE_W'(SAMPLE_MIN), 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd1, 1'b0);
        send_sample(-16'sd3, 1'b1);
        // chunk of a single zero sample
        send_sample(16'sd0, 1'b1);
        drain();

        // unity gain, the largest level comes from a chunk of pure minimum
        set_gain(16'd256);
        write_reg(REG_UNUSED, 32'hFFFF_1234);
        read_check(REG_GAIN_Q8, 32'd256);
        send_sample(SAMPLE_W'(SAMPLE_MIN), 1'b1);
        send_sample(SAMPLE_W'(SAMPLE_MAX), 1'b0);
        send_sample(SAMPLE_W'(SAMPLE_MIN), 1'b1);
        drain();

        // zero gain mutes the output and the level
        set_gain(16'd0);
        send_sample(16'sd12345, 1'b0);
        send_sample(SAMPLE_W'(SAMPLE_MIN), 1'b1);
        drain();

        // largest gain: small inputs scale, large ones clip
        set_gain(16'hFFFF);
        send_sample(16'sd1, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(-16'sd2, 1'b0);
        send_sample(SAMPLE_W'(SAMPLE_MAX), 1'b0);
        send_sample(SAMPLE_W'(SAMPLE_MIN), 1'b0);
        send_sample(16'sd128, 1'b0);
        send_sample(-16'sd129, 1'b1);
        drain();

        // random phases with short chunks at a spread of gains
        foreach (phase_gains[p])
        begin
            set_gain(phase_gains[p]);
            run_samples(10, 4, 0);
        end

        // longer chunks at a random gain
        set_gain(GAIN_W'($urandom_range(128, 1024)));
        run_samples(40, 15, 0);

        // last part without idling: a full chunk of minimum samples fills the
        // square sum to its top and closes on the count, then more follow
        idling_on = 1'b0;
        set_gain(16'd256);
        run_samples(MAX_CHUNK_SAMPLES + 16, 0, MAX_CHUNK_SAMPLES);

        // let any stray word show up before the verdict
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tracker.pending() != 0)
            tracker.note_mismatch("words still due at the end", 0,
                                  tracker.pending());

        $display("covered %0d samples and %0d output words over %0d gain settings",
                 samples_sent, tracker.words_seen, gain_settings);
        $display("%0d chunks closed, %0d of them on the full count, %0d mismatches",
                 tracker.chunks_closed, tracker.full_closes, tracker.mismatches);
        if (tracker.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
